// ----- src/gac_pkg.sv -----
`default_nettype none
package gac_pkg;

  localparam int AXIS_COUNT = 6;
  localparam int AXIS_W     = 3;
  localparam int SAMPLE_W   = 16;
  localparam int THR_W      = 15;
  localparam int KEY_W      = 6;
  localparam int ARROW_W    = 4;
  localparam int STICK_DZ_N = 4;
  localparam int REG_IDX_W  = 3;

  // axis codes
  localparam logic [AXIS_W-1:0] AX_SIDE  = 3'd0;
  localparam logic [AXIS_W-1:0] AX_FWD   = 3'd1;
  localparam logic [AXIS_W-1:0] AX_PITCH = 3'd2;
  localparam logic [AXIS_W-1:0] AX_YAW   = 3'd3;
  localparam logic [AXIS_W-1:0] AX_RT    = 3'd4;
  localparam logic [AXIS_W-1:0] AX_LT    = 3'd5;

  // key bit positions
  localparam int KEY_UP    = 0;
  localparam int KEY_DOWN  = 1;
  localparam int KEY_LEFT  = 2;
  localparam int KEY_RIGHT = 3;
  localparam int KEY_TRIG1 = 4;
  localparam int KEY_TRIG2 = 5;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_LT_THR       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RT_THR       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIDE_KEY_THR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FWD_KEY_THR  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SIDE_DZ      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FWD_DZ       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PITCH_DZ     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_YAW_DZ       = 3'd7;

  localparam logic [THR_W-1:0] TRIG_THR_RESET = 15'd16384;
  localparam logic [THR_W-1:0] KEY_THR_RESET  = 15'd24576;
  localparam logic [THR_W-1:0] DZ_RESET       = 15'd4096;

  typedef struct packed {
    logic [AXIS_W-1:0]          axis;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       menu_focus;
  } in_item_t;

  typedef struct packed {
    logic                       updated;
    logic signed [SAMPLE_W-1:0] filtered_value;
    logic [KEY_W-1:0]           key_press;
    logic [KEY_W-1:0]           key_release;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0]                 lt_thr;
    logic [THR_W-1:0]                 rt_thr;
    logic [THR_W-1:0]                 side_key_thr;
    logic [THR_W-1:0]                 fwd_key_thr;
    logic [STICK_DZ_N-1:0][THR_W-1:0] deadzone;
  } cfg_t;

endpackage
`default_nettype wire

// ----- src/gac_cfg.sv -----
`default_nettype none
module gac_cfg
  import gac_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lt_thr       <= TRIG_THR_RESET;
      cfg.rt_thr       <= TRIG_THR_RESET;
      cfg.side_key_thr <= KEY_THR_RESET;
      cfg.fwd_key_thr  <= KEY_THR_RESET;
      cfg.deadzone     <= {STICK_DZ_N{DZ_RESET}};
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LT_THR:       cfg.lt_thr       <= cfg_data;
        REG_RT_THR:       cfg.rt_thr       <= cfg_data;
        REG_SIDE_KEY_THR: cfg.side_key_thr <= cfg_data;
        REG_FWD_KEY_THR:  cfg.fwd_key_thr  <= cfg_data;
        REG_SIDE_DZ:      cfg.deadzone[0]  <= cfg_data;
        REG_FWD_DZ:       cfg.deadzone[1]  <= cfg_data;
        REG_PITCH_DZ:     cfg.deadzone[2]  <= cfg_data;
        REG_YAW_DZ:       cfg.deadzone[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/gac_eval.sv -----
`default_nettype none
module gac_eval
  import gac_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  logic signed [SAMPLE_W-1:0] cur [AXIS_COUNT];
  logic signed [SAMPLE_W-1:0] prev_side;
  logic signed [SAMPLE_W-1:0] prev_fwd;
  logic [ARROW_W-1:0]         arrows_down;

  logic                       valid_ax;
  logic                       is_trig;
  logic                       is_rt;
  logic                       upd;
  logic signed [SAMPLE_W-1:0] cur_sel;
  logic signed [SAMPLE_W-1:0] new_val;
  logic signed [SAMPLE_W:0]   v_ext;
  logic signed [SAMPLE_W:0]   old_ext;
  logic signed [SAMPLE_W:0]   trig_thr;
  logic signed [SAMPLE_W:0]   dz;
  logic                       in_dz;
  logic signed [SAMPLE_W-1:0] side_cur_n;
  logic signed [SAMPLE_W-1:0] side_prev_n;
  logic signed [SAMPLE_W-1:0] fwd_cur_n;
  logic signed [SAMPLE_W-1:0] fwd_prev_n;
  logic [1:0]                 side_dir;
  logic [1:0]                 fwd_dir;
  logic [ARROW_W-1:0]         hat;
  logic                       arrow_eval;
  logic [ARROW_W-1:0]         arrows_next;
  logic [KEY_W-1:0]           press;
  logic [KEY_W-1:0]           release_bits;

  // {positive crossing, negative crossing}
  function automatic logic [1:0] hat_dir(logic signed [SAMPLE_W-1:0] c,
                                         logic signed [SAMPLE_W-1:0] p,
                                         logic [THR_W-1:0] thr);
    logic signed [SAMPLE_W:0] ce;
    logic signed [SAMPLE_W:0] pe;
    logic signed [SAMPLE_W:0] te;
    ce = {c[SAMPLE_W-1], c};
    pe = {p[SAMPLE_W-1], p};
    te = $signed({2'b00, thr});
    if (ce > te && pe <= te) begin
      hat_dir = 2'b10;
    end else if (ce < -te && pe >= -te) begin
      hat_dir = 2'b01;
    end else begin
      hat_dir = 2'b00;
    end
  endfunction

  always_comb begin
    valid_ax = (item.axis < AXIS_W'(AXIS_COUNT));
    is_trig  = (item.axis == AX_RT) || (item.axis == AX_LT);
    is_rt    = (item.axis == AX_RT);

    cur_sel = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      if (item.axis == AXIS_W'(i)) begin
        cur_sel = cur[i];
      end
    end

    upd      = valid_ax && (item.sample != cur_sel);
    v_ext    = {item.sample[SAMPLE_W-1], item.sample};
    old_ext  = {cur_sel[SAMPLE_W-1], cur_sel};
    trig_thr = $signed({2'b00, (is_rt ? cfg.rt_thr : cfg.lt_thr)});
    dz       = $signed({2'b00, cfg.deadzone[item.axis[1:0]]});
    in_dz    = (v_ext < dz) && (v_ext > -dz);
    new_val  = (!is_trig && in_dz) ? '0 : item.sample;

    press        = '0;
    release_bits = '0;
    if (upd && is_trig) begin
      if (v_ext > trig_thr && old_ext <= trig_thr) begin
        press[is_rt ? KEY_TRIG2 : KEY_TRIG1] = 1'b1;
      end else if (v_ext < trig_thr && old_ext >= trig_thr) begin
        release_bits[is_rt ? KEY_TRIG2 : KEY_TRIG1] = 1'b1;
      end
    end

    // both sticks seen as they stand after this update
    side_cur_n  = (item.axis == AX_SIDE) ? new_val : cur[AX_SIDE];
    side_prev_n = (item.axis == AX_SIDE) ? cur[AX_SIDE] : prev_side;
    fwd_cur_n   = (item.axis == AX_FWD) ? new_val : cur[AX_FWD];
    fwd_prev_n  = (item.axis == AX_FWD) ? cur[AX_FWD] : prev_fwd;
    side_dir    = hat_dir(side_cur_n, side_prev_n, cfg.side_key_thr);
    fwd_dir     = hat_dir(fwd_cur_n, fwd_prev_n, cfg.fwd_key_thr);

    hat            = '0;
    hat[KEY_LEFT]  = side_dir[0];
    hat[KEY_RIGHT] = side_dir[1];
    hat[KEY_UP]    = fwd_dir[0];
    hat[KEY_DOWN]  = fwd_dir[1];

    arrow_eval  = upd && item.menu_focus &&
                  ((item.axis == AX_SIDE) || (item.axis == AX_FWD));
    arrows_next = arrows_down;
    if (arrow_eval) begin
      press[ARROW_W-1:0]        = hat & ~arrows_down;
      release_bits[ARROW_W-1:0] = ~hat & arrows_down;
      arrows_next               = hat;
    end

    result.updated        = upd;
    result.filtered_value = !valid_ax ? '0 : (upd ? new_val : cur_sel);
    result.key_press      = press;
    result.key_release    = release_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        cur[i] <= '0;
      end
      prev_side   <= '0;
      prev_fwd    <= '0;
      arrows_down <= '0;
    end else if (fire) begin
      arrows_down <= arrows_next;
      if (upd) begin
        for (int i = 0; i < AXIS_COUNT; i++) begin
          if (item.axis == AXIS_W'(i)) begin
            cur[i] <= new_val;
          end
        end
        if (item.axis == AX_SIDE) begin
          prev_side <= cur_sel;
        end
        if (item.axis == AX_FWD) begin
          prev_fwd <= cur_sel;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_press_release_disjoint: assert property (@(posedge clk) disable iff (rst)
    fire |-> ((result.key_press & result.key_release) == '0))
    else $error("key pressed and released in one transaction");

  a_no_keys_without_update: assert property (@(posedge clk) disable iff (rst)
    (fire && !result.updated) |-> (result.key_press == '0 && result.key_release == '0))
    else $error("key event on a transaction that was not an update");

  a_arrows_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(arrows_down))
    else $error("arrow key state changed without a transaction");

  a_arrow_press_was_up: assert property (@(posedge clk) disable iff (rst)
    fire |-> ((result.key_press[ARROW_W-1:0] & arrows_down) == '0))
    else $error("arrow key pressed while already down");
`endif

endmodule
`default_nettype wire

// ----- src/gamepad_axis_conditioner_top.sv -----
`default_nettype none
// Gamepad axis conditioner.
// Sample channel (sample_valid / sample_stall / sample_data) carries one axis
// sample per transaction; result channel (result_valid / result_stall /
// result_data) returns exactly one result per sample, in order.
// A transaction completes on a rising edge with valid high and stall low.
// A sample is taken into the input register and evaluated into the result
// register. Throughput: one sample per cycle while the result does not stall,
// set by the single evaluate-and-update pass between the two registers, where
// all per-axis state is read and written in the same cycle.
// When the receiver stalls, the result register holds; the input register
// still takes one more sample, then sample_stall rises until the result moves.
// Configuration registers are written through cfg_wr_en / cfg_index /
// cfg_data. The user must write only while no sample is in flight (unenforced).
// Synchronous reset clears stored axis values, the arrow-key state and both
// pipeline valid flags, and returns the configuration registers to defaults.
module gamepad_axis_conditioner_top
  import gac_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output      logic                 sample_stall,
  input  wire in_item_t             sample_data,
  output      logic                 result_valid,
  input  wire logic                 result_stall,
  output out_item_t                 result_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_data
);

  cfg_t      cfg;
  in_item_t  in_item;
  logic      in_vld;
  logic      advance;
  logic      fire;
  logic      take;
  out_item_t eval_result;

  assign advance      = !result_valid || !result_stall;
  assign fire         = in_vld && advance;
  assign sample_stall = in_vld && !advance;
  assign take         = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (take) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item <= sample_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_data <= eval_result;
    end
  end

  gac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gac_eval u_eval (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg    (cfg),
    .result (eval_result)
  );

`ifndef NO_ASSERTIONS
  a_input_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !advance) |=> in_vld)
    else $error("pending transaction dropped from input register");

  a_result_follows_fire: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("evaluated transaction did not reach result register");

  a_result_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result_data)))
    else $error("stalled result transaction changed");
`endif

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import gac_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 4000;
  localparam int SAMPLE_MAX  = 32767;
  localparam int SAMPLE_MIN  = -32768;
  localparam int THR_MAX     = 32767;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  in_item_t             sample_data = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  out_item_t            result_data;
  logic                 cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_data = '0;

  // shadow of the block's registers and state
  logic [THR_W-1:0]           shadow_reg [8];
  logic signed [SAMPLE_W-1:0] axis_value [AXIS_COUNT];
  logic signed [SAMPLE_W-1:0] axis_before [AXIS_COUNT];
  logic [ARROW_W-1:0]         arrows_held;

  out_item_t pending_results [$];
  out_item_t want;
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        stuck_cycles = 0;
  logic      holding = 1'b0;
  event      hold_go;

  gamepad_axis_conditioner_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Edge pair of one stick against its arrow-key level.
  function automatic logic [ARROW_W-1:0] stick_cross(logic [AXIS_W-1:0] ax, int thr,
                                                     int neg_key, int pos_key);
    int now_v;
    int was_v;
    logic [ARROW_W-1:0] hat;
    now_v = axis_value[ax];
    was_v = axis_before[ax];
    hat = '0;
    if (now_v > thr && was_v <= thr) hat[pos_key] = 1'b1;
    else if (now_v < -thr && was_v >= -thr) hat[neg_key] = 1'b1;
    return hat;
  endfunction

  function automatic out_item_t condition_sample(in_item_t it);
    out_item_t r;
    int v;
    int thr;
    int dz;
    int was_v;
    int trig_key;
    logic [ARROW_W-1:0] hat;
    r = '0;
    if (int'(it.axis) < AXIS_COUNT) begin
      r.filtered_value = axis_value[it.axis];
      if (it.sample != axis_value[it.axis]) begin
        r.updated = 1'b1;
        v = $signed(it.sample);
        was_v = axis_value[it.axis];
        axis_before[it.axis] = axis_value[it.axis];
        if (it.axis == AX_RT || it.axis == AX_LT) begin
          thr = (it.axis == AX_RT) ? shadow_reg[REG_RT_THR] : shadow_reg[REG_LT_THR];
          trig_key = (it.axis == AX_RT) ? KEY_TRIG2 : KEY_TRIG1;
          axis_value[it.axis] = it.sample;
          if (v > thr && was_v <= thr) r.key_press[trig_key] = 1'b1;
          else if (v < thr && was_v >= thr) r.key_release[trig_key] = 1'b1;
        end else begin
          dz = shadow_reg[int'(REG_SIDE_DZ) + int'(it.axis)];
          if (v < dz && v > -dz) v = 0;
          axis_value[it.axis] = 16'(v);
          if ((it.axis == AX_SIDE || it.axis == AX_FWD) && it.menu_focus) begin
            // both sticks are judged, whichever one moved
            hat = stick_cross(AX_SIDE, shadow_reg[REG_SIDE_KEY_THR], KEY_LEFT, KEY_RIGHT)
                | stick_cross(AX_FWD, shadow_reg[REG_FWD_KEY_THR], KEY_UP, KEY_DOWN);
            for (int k = 0; k < ARROW_W; k++) begin
              if (hat[k] && !arrows_held[k]) begin
                r.key_press[k] = 1'b1;
                arrows_held[k] = 1'b1;
              end else if (!hat[k] && arrows_held[k]) begin
                r.key_release[k] = 1'b1;
                arrows_held[k] = 1'b0;
              end
            end
          end
        end
        r.filtered_value = axis_value[it.axis];
      end
    end
    return r;
  endfunction

  // Mostly sticks that feed the arrow keys, values near the active levels.
  function automatic in_item_t random_sample();
    in_item_t it;
    int r;
    int v;
    int lvl;
    r = $urandom_range(99);
    if (r < 5) it.axis = 3'($urandom_range(6, 7));
    else if (r < 62) it.axis = 3'($urandom_range(0, 1));
    else it.axis = 3'($urandom_range(2, 5));
    it.menu_focus = ($urandom_range(99) < 75);
    case (it.axis)
      AX_RT:   lvl = shadow_reg[REG_RT_THR];
      AX_LT:   lvl = shadow_reg[REG_LT_THR];
      AX_SIDE: lvl = $urandom_range(1) ? shadow_reg[REG_SIDE_KEY_THR] : shadow_reg[REG_SIDE_DZ];
      AX_FWD:  lvl = $urandom_range(1) ? shadow_reg[REG_FWD_KEY_THR] : shadow_reg[REG_FWD_DZ];
      default: lvl = shadow_reg[int'(REG_SIDE_DZ) + int'(it.axis[1:0])];
    endcase
    r = $urandom_range(99);
    if (r < 25) begin
      v = int'($urandom_range(65535)) - 32768;
    end else if (r < 33) begin
      v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    end else if (r < 40 && int'(it.axis) < AXIS_COUNT) begin
      v = axis_value[it.axis];
    end else begin
      if ($urandom_range(1)) lvl = -lvl;
      v = lvl + int'($urandom_range(4)) - 2;
    end
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    it.sample = 16'(v);
    return it;
  endfunction

  task automatic send_sample(input logic [AXIS_W-1:0] ax, input logic signed [SAMPLE_W-1:0] val,
                             input logic focus);
    in_item_t it;
    out_item_t r;
    it.axis = ax;
    it.sample = val;
    it.menu_focus = focus;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_data  <= it;
    do @(posedge clk); while (sample_stall);
    r = condition_sample(it);
    pending_results.push_back(r);
  endtask

  // Drop valid, wait for every result, then let the pipeline empty.
  task automatic settle_block();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    shadow_reg[idx] = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_all(input logic [THR_W-1:0] val);
    settle_block();
    for (int i = 0; i < 8; i++) write_reg(3'(i), val);
  endtask

  task automatic send_random(input int goal);
    in_item_t it;
    for (int n = 0; n < goal; n++) begin
      it = random_sample();
      send_sample(it.axis, it.sample, it.menu_focus);
    end
  endtask

  task automatic test_directed();
    // arrow keys from the side stick, default levels
    send_sample(AX_SIDE, 16'sd32767, 1'b1);
    send_sample(AX_SIDE, 16'sd32767, 1'b1);
    send_sample(AX_SIDE, 16'sh8000, 1'b1);
    send_sample(AX_SIDE, 16'sd100, 1'b1);
    // no focus leaves the arrows alone
    send_sample(AX_FWD, 16'sd30000, 1'b0);
    send_sample(AX_FWD, -16'sd30000, 1'b1);
    // side moves inside its deadzone; forward crossing still seen
    send_sample(AX_SIDE, 16'sd1, 1'b1);
    send_sample(AX_FWD, 16'sd0, 1'b1);
    // deadzone edges
    send_sample(AX_PITCH, 16'sd4095, 1'b0);
    send_sample(AX_PITCH, -16'sd4096, 1'b0);
    send_sample(AX_PITCH, 16'sd4096, 1'b0);
    send_sample(AX_YAW, 16'sh8000, 1'b0);
    send_sample(AX_YAW, 16'sd32767, 1'b1);
    // trigger at, above and back to its threshold
    send_sample(AX_RT, 16'sd16384, 1'b0);
    send_sample(AX_RT, 16'sd16385, 1'b0);
    send_sample(AX_RT, 16'sd16384, 1'b0);
    send_sample(AX_RT, 16'sd0, 1'b0);
    send_sample(AX_LT, 16'sd32767, 1'b1);
    send_sample(AX_LT, 16'sh8000, 1'b1);
    send_sample(AX_LT, 16'sh8000, 1'b1);
    // unused axes
    send_sample(3'd6, 16'sh5555, 1'b1);
    send_sample(3'd7, 16'shAAAA, 1'b0);
    send_sample(AX_SIDE, -16'sd25000, 1'b1);
  endtask

  task automatic test_extreme_config();
    load_all('0);
    send_random(100);
    load_all(THR_W'(THR_MAX));
    send_random(100);
  endtask

  task automatic test_random_config(input int goal);
    int r;
    settle_block();
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(99);
      if (r < 10) write_reg(3'(i), '0);
      else if (r < 20) write_reg(3'(i), THR_W'(THR_MAX));
      else write_reg(3'(i), THR_W'($urandom_range(THR_MAX)));
    end
    send_random(goal);
  endtask

  task automatic test_backpressure();
    -> hold_go;
    send_random(40);
  endtask

  // receiver-side long hold-off
  initial begin
    forever begin
      @(hold_go);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding = 1'b0;
    end
  end

  always @(negedge clk) begin
    result_stall <= holding || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_data.updated !== want.updated) begin
          $error("updated: expected %0d, got %0d", want.updated, result_data.updated);
          errors++;
        end
        if (result_data.filtered_value !== want.filtered_value) begin
          $error("filtered_value: expected %0d, got %0d",
                 $signed(want.filtered_value), $signed(result_data.filtered_value));
          errors++;
        end
        if (result_data.key_press !== want.key_press) begin
          $error("key_press: expected %b, got %b", want.key_press, result_data.key_press);
          errors++;
        end
        if (result_data.key_release !== want.key_release) begin
          $error("key_release: expected %b, got %b", want.key_release,
                 result_data.key_release);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    shadow_reg[REG_LT_THR]       = TRIG_THR_RESET;
    shadow_reg[REG_RT_THR]       = TRIG_THR_RESET;
    shadow_reg[REG_SIDE_KEY_THR] = KEY_THR_RESET;
    shadow_reg[REG_FWD_KEY_THR]  = KEY_THR_RESET;
    shadow_reg[REG_SIDE_DZ]      = DZ_RESET;
    shadow_reg[REG_FWD_DZ]       = DZ_RESET;
    shadow_reg[REG_PITCH_DZ]     = DZ_RESET;
    shadow_reg[REG_YAW_DZ]       = DZ_RESET;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      axis_value[i]  = '0;
      axis_before[i] = '0;
    end
    arrows_held = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    recv_idle_pct = 53;
    test_directed();
    test_extreme_config();
    test_random_config(200);

    send_idle_pct = 53;
    recv_idle_pct = 35;
    test_random_config(180);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_config(180);
    test_backpressure();

    settle_block();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
